// ----- rtl/core/gap_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the grid path finder.
// No dependencies.
package gap_pkg;

    // width of the used-size values, enough for a 64-wide grid
    localparam int SZ_W = 7;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [4:0] {
        ST_MAPCLR,
        ST_IDLE,
        ST_RES1,
        ST_CLR,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_SH_RD,
        ST_SH_WR,
        ST_CLOSE,
        ST_NB_RD,
        ST_NB_EV,
        ST_NB_END,
        ST_TR_RD,
        ST_TR_EV,
        ST_EM_RD,
        ST_EM_LD
    } gap_state_t;

endpackage

// ----- rtl/core/gap_ram.sv -----
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
// No dependencies.
module gap_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/grid_astar_path_finder.sv -----
`timescale 1ns / 1ps
// Grid A* path finder: walkability map, open list, node store and path buffer in RAMs.
// Depends on gap_pkg and gap_ram.
//
// Usage:
//   in channel (in_valid/in_ready): mode 0 writes one cell's blocked mark, mode 1
//   runs a 4-connected A* search from start to goal. in_ready is high only while
//   the sequencer is idle, so one item is worked on at a time.
//   out channel (out_valid/out_ready): path cells from start to goal, start
//   excluded, last set on the final beat; or one beat with has_step low.
//   cfg channel (cfg_valid/cfg_ready): index 0 grid width, index 1 grid height;
//   always ready, write only while idle.
// Operation:
//   A search first clears the node store, then for each expansion scans the
//   open list, removes the picked entry by shifting the later entries down
//   and visits four neighbours, skipping any off the grid. Path output first
//   traces the parents back from the goal into the path buffer, then emits
//   the buffered cells as beats. The open list scan and shift dominate.
// Reset:
//   after reset the map is swept to all walkable, one cell a cycle, before
//   the first item is taken.
// Stall:
//   a held output beat blocks the sequencer until it is taken.
module grid_astar_path_finder
    import gap_pkg::*;
#(
    parameter int MAX_WIDTH  = 8,
    parameter int MAX_HEIGHT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [2:0] cell_x,
    input  logic [2:0] cell_y,
    input  logic       blocked,
    input  logic [2:0] start_x,
    input  logic [2:0] start_y,
    input  logic [2:0] goal_x,
    input  logic [2:0] goal_y,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] step_x,
    output logic [2:0] step_y,
    output logic       has_step,
    output logic       found,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int DEP = 1 << AW;
    localparam int CW  = AW + 1;
    localparam int GW  = AW + 1;
    localparam int HW  = ((XW > YW) ? XW : YW) + 1;
    localparam int FW  = GW + 1;

    typedef struct packed {
        logic [GW-1:0] g;
        logic [HW-1:0] h;
        logic [AW-1:0] parent;
        logic          in_open;
        logic          closed;
    } node_t;
    localparam int NW = $bits(node_t);

    function automatic logic [XW-1:0] cx_of(input logic [AW-1:0] c);
        return c[XW-1:0];
    endfunction
    function automatic logic [YW-1:0] cy_of(input logic [AW-1:0] c);
        return c[AW-1:XW];
    endfunction
    function automatic logic [HW-1:0] manh(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [HW-1:0] dx;
        logic [HW-1:0] dy;
        dx = (cx_of(a) > cx_of(b)) ? HW'(cx_of(a) - cx_of(b)) : HW'(cx_of(b) - cx_of(a));
        dy = (cy_of(a) > cy_of(b)) ? HW'(cy_of(a) - cy_of(b)) : HW'(cy_of(b) - cy_of(a));
        return dx + dy;
    endfunction

    gap_state_t state_reg, state_next;

    logic [3:0]    gw_reg, gw_next, gh_reg, gh_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] start_reg, start_next, goal_reg, goal_next;
    logic          res_found_reg, res_found_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          s1_v_reg, s1_v_next, s2_v_reg, s2_v_next;
    logic [AW-1:0] s1_idx_reg, s1_idx_next, s2_idx_reg, s2_idx_next;
    logic [AW-1:0] s2_cell_reg, s2_cell_next;
    logic [AW-1:0] best_idx_reg, best_idx_next, best_cell_reg, best_cell_next;
    node_t         best_reg, best_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [1:0]    dir_reg, dir_next;
    logic [AW-1:0] nb_reg, nb_next;
    logic [AW-1:0] tr_reg, tr_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] em_reg, em_next;
    logic          out_v_reg, out_v_next;
    logic [2:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic          oh_reg, oh_next, of_reg, of_next, ol_reg, ol_next;

    // RAM ports
    logic          wk_we, wk_wd, wk_rd;
    logic [AW-1:0] wk_wa, wk_ra;
    logic          nd_we;
    logic [AW-1:0] nd_wa, nd_ra;
    node_t         nd_wd, nd_rd;
    logic [NW-1:0] nd_rd_raw;
    logic          op_we;
    logic [AW-1:0] op_wa, op_ra, op_wd, op_rd;
    logic          pb_we;
    logic [AW-1:0] pb_wa, pb_ra, pb_wd, pb_rd;

    gap_ram #(.W(1), .D(DEP)) u_walk (
        .clk(clk), .we(wk_we), .waddr(wk_wa), .wdata(wk_wd), .raddr(wk_ra), .rdata(wk_rd)
    );
    gap_ram #(.W(NW), .D(DEP)) u_node (
        .clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd_raw)
    );
    gap_ram #(.W(AW), .D(DEP)) u_open (
        .clk(clk), .we(op_we), .waddr(op_wa), .wdata(op_wd), .raddr(op_ra), .rdata(op_rd)
    );
    gap_ram #(.W(AW), .D(DEP)) u_path (
        .clk(clk), .we(pb_we), .waddr(pb_wa), .wdata(pb_wd), .raddr(pb_ra), .rdata(pb_rd)
    );
    assign nd_rd = node_t'(nd_rd_raw);

    // size in use, clamped to 1..max
    logic [SZ_W-1:0] used_w, used_h;
    always_comb
    begin
        if (gw_reg == 4'd0)
            used_w = SZ_W'(1);
        else if (SZ_W'(gw_reg) > SZ_W'(MAX_WIDTH))
            used_w = SZ_W'(MAX_WIDTH);
        else
            used_w = SZ_W'(gw_reg);
        if (gh_reg == 4'd0)
            used_h = SZ_W'(1);
        else if (SZ_W'(gh_reg) > SZ_W'(MAX_HEIGHT))
            used_h = SZ_W'(MAX_HEIGHT);
        else
            used_h = SZ_W'(gh_reg);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign step_x    = ox_reg;
    assign step_y    = oy_reg;
    assign has_step  = oh_reg;
    assign found     = of_reg;
    assign last      = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MAPCLR;
            gw_reg        <= 4'd8;
            gh_reg        <= 4'd8;
            clr_reg       <= '0;
            start_reg     <= '0;
            goal_reg      <= '0;
            res_found_reg <= 1'b0;
            count_reg     <= '0;
            scan_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s1_idx_reg    <= '0;
            s2_idx_reg    <= '0;
            s2_cell_reg   <= '0;
            best_idx_reg  <= '0;
            best_cell_reg <= '0;
            best_reg      <= '0;
            sh_reg        <= '0;
            dir_reg       <= '0;
            nb_reg        <= '0;
            tr_reg        <= '0;
            len_reg       <= '0;
            em_reg        <= '0;
            out_v_reg     <= 1'b0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oh_reg        <= 1'b0;
            of_reg        <= 1'b0;
            ol_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
            clr_reg       <= clr_next;
            start_reg     <= start_next;
            goal_reg      <= goal_next;
            res_found_reg <= res_found_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            s1_idx_reg    <= s1_idx_next;
            s2_idx_reg    <= s2_idx_next;
            s2_cell_reg   <= s2_cell_next;
            best_idx_reg  <= best_idx_next;
            best_cell_reg <= best_cell_next;
            best_reg      <= best_next;
            sh_reg        <= sh_next;
            dir_reg       <= dir_next;
            nb_reg        <= nb_next;
            tr_reg        <= tr_next;
            len_reg       <= len_next;
            em_reg        <= em_next;
            out_v_reg     <= out_v_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            oh_reg        <= oh_next;
            of_reg        <= of_next;
            ol_reg        <= ol_next;
        end
    end

    logic [XW-1:0]   cur_x, nx;
    logic [YW-1:0]   cur_y, ny;
    logic            nb_ok;
    logic [FW-1:0]   f_new, f_best;
    logic [GW-1:0]   g_new;

    always_comb
    begin
        state_next     = state_reg;
        gw_next        = gw_reg;
        gh_next        = gh_reg;
        clr_next       = clr_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        res_found_next = res_found_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        s1_v_next      = 1'b0;
        s2_v_next      = 1'b0;
        s1_idx_next    = s1_idx_reg;
        s2_idx_next    = s1_idx_reg;
        s2_cell_next   = op_rd;
        best_idx_next  = best_idx_reg;
        best_cell_next = best_cell_reg;
        best_next      = best_reg;
        sh_next        = sh_reg;
        dir_next       = dir_reg;
        nb_next        = nb_reg;
        tr_next        = tr_reg;
        len_next       = len_reg;
        em_next        = em_reg;
        out_v_next     = out_v_reg && !out_ready;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oh_next        = oh_reg;
        of_next        = of_reg;
        ol_next        = ol_reg;

        wk_we = 1'b0; wk_wa = clr_reg; wk_wd = 1'b0; wk_ra = nb_reg;
        nd_we = 1'b0; nd_wa = clr_reg; nd_wd = '0;   nd_ra = nb_reg;
        op_we = 1'b0; op_wa = '0;      op_wd = '0;   op_ra = '0;
        pb_we = 1'b0; pb_wa = len_reg; pb_wd = tr_reg;
        pb_ra = AW'(len_reg - em_reg - AW'(1));

        cur_x  = cx_of(best_cell_reg);
        cur_y  = cy_of(best_cell_reg);
        nx     = cur_x;
        ny     = cur_y;
        nb_ok  = 1'b0;
        unique case (dir_reg)
            2'd0:
            begin
                nb_ok = (cur_x != '0);
                nx    = cur_x - XW'(1);
            end
            2'd1:
            begin
                nb_ok = (SZ_W'(cur_x) + SZ_W'(1) < used_w);
                nx    = cur_x + XW'(1);
            end
            2'd2:
            begin
                nb_ok = (cur_y != '0);
                ny    = cur_y - YW'(1);
            end
            default:
            begin
                nb_ok = (SZ_W'(cur_y) + SZ_W'(1) < used_h);
                ny    = cur_y + YW'(1);
            end
        endcase
        g_new  = best_reg.g + GW'(1);
        f_new  = FW'(nd_rd.g) + FW'(nd_rd.h);
        f_best = FW'(best_reg.g) + FW'(best_reg.h);

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  gw_next = cfg_data;
                CFG_HEIGHT: gh_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_MAPCLR:
            begin
                wk_we    = 1'b1;
                wk_wa    = clr_reg;
                wk_wd    = 1'b0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEP - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        if (SZ_W'(cell_x) < used_w && SZ_W'(cell_y) < used_h)
                        begin
                            wk_we = 1'b1;
                            wk_wa = {YW'(cell_y), XW'(cell_x)};
                            wk_wd = blocked;
                        end
                    end
                    else
                    begin
                        start_next = {YW'(start_y), XW'(start_x)};
                        goal_next  = {YW'(goal_y), XW'(goal_x)};
                        if (SZ_W'(start_x) >= used_w || SZ_W'(start_y) >= used_h ||
                            SZ_W'(goal_x) >= used_w || SZ_W'(goal_y) >= used_h)
                        begin
                            res_found_next = 1'b0;
                            state_next     = ST_RES1;
                        end
                        else
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                    end
                end
            end
            ST_RES1:
            begin
                if (!out_v_reg)
                begin
                    out_v_next = 1'b1;
                    ox_next    = '0;
                    oy_next    = '0;
                    oh_next    = 1'b0;
                    of_next    = res_found_reg;
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                nd_we    = 1'b1;
                nd_wa    = clr_reg;
                nd_wd    = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEP - 1))
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                nd_we         = 1'b1;
                nd_wa         = start_reg;
                nd_wd         = '0;
                nd_wd.in_open = 1'b1;
                op_we         = 1'b1;
                op_wa         = '0;
                op_wd         = start_reg;
                count_next    = CW'(1);
                scan_next     = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // three-stage scan: open list read, node read, compare
                op_ra = scan_reg[AW-1:0];
                if (scan_reg < count_reg)
                begin
                    s1_v_next   = 1'b1;
                    s1_idx_next = scan_reg[AW-1:0];
                    scan_next   = scan_reg + CW'(1);
                end
                nd_ra     = op_rd;
                s2_v_next = s1_v_reg;
                if (s2_v_reg)
                begin
                    if (s2_idx_reg == '0 || f_new < f_best ||
                        (f_new == f_best && nd_rd.h < best_reg.h))
                    begin
                        best_idx_next  = s2_idx_reg;
                        best_cell_next = s2_cell_reg;
                        best_next      = nd_rd;
                    end
                end
                if (scan_reg >= count_reg && !s1_v_reg && !s2_v_reg)
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                sh_next = CW'(best_idx_reg);
                if (CW'(best_idx_reg) + CW'(1) < count_reg)
                    state_next = ST_SH_RD;
                else
                    state_next = ST_CLOSE;
            end
            ST_SH_RD:
            begin
                op_ra      = AW'(sh_reg + CW'(1));
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                op_we   = 1'b1;
                op_wa   = sh_reg[AW-1:0];
                op_wd   = op_rd;
                sh_next = sh_reg + CW'(1);
                if (sh_reg + CW'(2) < count_reg)
                    state_next = ST_SH_RD;
                else
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                count_next    = count_reg - CW'(1);
                nd_we         = 1'b1;
                nd_wa         = best_cell_reg;
                nd_wd         = best_reg;
                nd_wd.in_open = 1'b0;
                nd_wd.closed  = 1'b1;
                if (best_cell_reg == goal_reg)
                begin
                    tr_next    = goal_reg;
                    len_next   = '0;
                    state_next = ST_TR_RD;
                end
                else
                begin
                    dir_next   = 2'd0;
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_RD:
            begin
                wk_ra   = {ny, nx};
                nd_ra   = {ny, nx};
                nb_next = {ny, nx};
                if (nb_ok)
                    state_next = ST_NB_EV;
                else if (dir_reg == 2'd3)
                    state_next = ST_NB_END;
                else
                    dir_next = dir_reg + 2'd1;
            end
            ST_NB_EV:
            begin
                if (!nd_rd.closed && !wk_rd && (g_new < nd_rd.g || !nd_rd.in_open))
                begin
                    nd_we         = 1'b1;
                    nd_wa         = nb_reg;
                    nd_wd.g       = g_new;
                    nd_wd.h       = manh(nb_reg, goal_reg);
                    nd_wd.parent  = best_cell_reg;
                    nd_wd.in_open = 1'b1;
                    nd_wd.closed  = 1'b0;
                    if (!nd_rd.in_open)
                    begin
                        op_we      = 1'b1;
                        op_wa      = count_reg[AW-1:0];
                        op_wd      = nb_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                if (dir_reg == 2'd3)
                    state_next = ST_NB_END;
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_END:
            begin
                scan_next = '0;
                if (count_reg == '0)
                begin
                    res_found_next = 1'b0;
                    state_next     = ST_RES1;
                end
                else
                    state_next = ST_SCAN;
            end
            ST_TR_RD:
            begin
                nd_ra = tr_reg;
                if (tr_reg == start_reg)
                begin
                    em_next = '0;
                    if (len_reg == '0)
                    begin
                        res_found_next = 1'b1;
                        state_next     = ST_RES1;
                    end
                    else
                        state_next = ST_EM_RD;
                end
                else
                begin
                    pb_we      = 1'b1;
                    pb_wa      = len_reg;
                    pb_wd      = tr_reg;
                    len_next   = len_reg + AW'(1);
                    state_next = ST_TR_EV;
                end
            end
            ST_TR_EV:
            begin
                tr_next    = nd_rd.parent;
                state_next = ST_TR_RD;
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                if (!out_v_reg)
                begin
                    out_v_next = 1'b1;
                    ox_next    = 3'(cx_of(pb_rd));
                    oy_next    = 3'(cy_of(pb_rd));
                    oh_next    = 1'b1;
                    of_next    = 1'b1;
                    ol_next    = (em_reg + AW'(1) == len_reg);
                    em_next    = em_reg + AW'(1);
                    if (em_reg + AW'(1) == len_reg)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_EM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- tb/sv/tb_grid_astar_path_finder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for grid_astar_path_finder: map writes and A* searches,
// checked beat by beat against an in-bench path predictor. Depends on gap_pkg and the RTL.
module tb_grid_astar_path_finder;
    import gap_pkg::*;

    typedef struct packed {
        logic       mode;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       blocked;
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } grid_item_t;

    typedef struct packed {
        logic [2:0] step_x;
        logic [2:0] step_y;
        logic       has_step;
        logic       found;
        logic       last;
    } path_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       blocked;
    logic [2:0] start_x;
    logic [2:0] start_y;
    logic [2:0] goal_x;
    logic [2:0] goal_y;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic       has_step;
    logic       found;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [3:0] cfg_data;

    grid_astar_path_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .blocked   (blocked),
        .start_x   (start_x),
        .start_y   (start_y),
        .goal_x    (goal_x),
        .goal_y    (goal_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .step_x    (step_x),
        .step_y    (step_y),
        .has_step  (has_step),
        .found     (found),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grid_item_t pending_items[$];
    path_beat_t expected_beats[$];
    int         errors      = 0;
    int         n_searches  = 0;
    int         n_writes    = 0;
    int         n_beats     = 0;
    int         n_found     = 0;

    // predictor state
    logic [3:0] reg_width;
    logic [3:0] reg_height;
    logic       walkable[64];

    logic       hold_go;
    logic       hold_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic int manhattan(input int a, input int b);
        int dx;
        int dy;
        dx = (a % 8) - (b % 8);
        dy = (a / 8) - (b / 8);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy;
    endfunction

    function automatic path_beat_t make_beat(input int cell_idx, input bit has, input bit fnd,
                                             input bit lst);
        path_beat_t b;
        b.step_x   = has ? 3'(cell_idx % 8) : 3'd0;
        b.step_y   = has ? 3'(cell_idx / 8) : 3'd0;
        b.has_step = has;
        b.found    = fnd;
        b.last     = lst;
        return b;
    endfunction

    // map write, or A* over the 4-connected grid queueing the beats a search should produce
    task automatic predict_path(input grid_item_t it);
        int w;
        int h;
        int gcost[64];
        int hcost[64];
        int parent[64];
        bit in_open[64];
        bit closed[64];
        int open_q[$];
        int dxs[4];
        int dys[4];
        int start;
        int goal;
        int bi;
        int cur;
        int nx;
        int ny;
        int n;
        int g;
        int fa;
        int fb;
        int trail[$];
        int c;
        w = (reg_width == 0) ? 1 : (reg_width > 8) ? 8 : reg_width;
        h = (reg_height == 0) ? 1 : (reg_height > 8) ? 8 : reg_height;
        dxs = '{-1, 1, 0, 0};
        dys = '{0, 0, -1, 1};
        if (it.mode == MODE_WRITE) begin
            n_writes++;
            if (it.cell_x < w && it.cell_y < h)
                walkable[it.cell_y * 8 + it.cell_x] = !it.blocked;
            return;
        end
        n_searches++;
        if (it.start_x >= w || it.start_y >= h || it.goal_x >= w || it.goal_y >= h) begin
            expected_beats = {expected_beats, make_beat(0, 1'b0, 1'b0, 1'b1)};
            return;
        end
        for (int i = 0; i < 64; i++) begin
            gcost[i] = 0; hcost[i] = 0; parent[i] = 0; in_open[i] = 0; closed[i] = 0;
        end
        start = it.start_y * 8 + it.start_x;
        goal  = it.goal_y * 8 + it.goal_x;
        open_q = {open_q, start};
        in_open[start] = 1;
        while (open_q.size() > 0) begin
            bi = 0;
            for (int i = 1; i < open_q.size(); i++) begin
                fa = gcost[open_q[i]] + hcost[open_q[i]];
                fb = gcost[open_q[bi]] + hcost[open_q[bi]];
                if (fa < fb || (fa == fb && hcost[open_q[i]] < hcost[open_q[bi]]))
                    bi = i;
            end
            cur = open_q[bi];
            open_q.delete(bi);
            in_open[cur] = 0;
            closed[cur] = 1;
            if (cur == goal) begin
                n_found++;
                c = goal;
                while (c != start && trail.size() < 64) begin
                    trail.push_front(c);
                    c = parent[c];
                end
                if (trail.size() == 0)
                    expected_beats = {expected_beats, make_beat(0, 1'b0, 1'b1, 1'b1)};
                foreach (trail[i])
                    expected_beats = {expected_beats,
                                      make_beat(trail[i], 1'b1, 1'b1, i == trail.size() - 1)};
                return;
            end
            for (int d = 0; d < 4; d++) begin
                nx = cur % 8 + dxs[d];
                ny = cur / 8 + dys[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                n = ny * 8 + nx;
                if (closed[n] || !walkable[n]) continue;
                g = gcost[cur] + 1;
                if (g < gcost[n] || !in_open[n]) begin
                    gcost[n]  = g;
                    hcost[n]  = manhattan(n, goal);
                    parent[n] = cur;
                    if (!in_open[n]) begin
                        open_q = {open_q, n};
                        in_open[n] = 1;
                    end
                end
            end
        end
        expected_beats = {expected_beats, make_beat(0, 1'b0, 1'b0, 1'b1)};
    endtask

    // driver: bursts of beats with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        grid_item_t nxt;
        bit         take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = 0;
            if (in_valid && in_ready)
                predict_path({mode, cell_x, cell_y, blocked, start_x, start_y, goal_x, goal_y});
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    take = 1;
                    nxt = pending_items.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                in_valid <= take;
                if (take)
                    {mode, cell_x, cell_y, blocked, start_x, start_y, goal_x, goal_y} <= nxt;
            end
        end
    end

    // receiver: stall pattern switches every so often, plus the long hold-off
    int stall_style = 0;
    int style_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 200);
            end
            style_left--;
            case (stall_style)
                0:       rdy = 1;
                1:       rdy = $urandom_range(0, 1);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            out_ready <= rdy && !hold_on;
        end
    end

    int hold_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_on <= 1'b0;
        end else if (hold_go && hold_count < 1500) begin
            hold_count <= hold_count + 1;
            hold_on    <= (hold_count < 1499);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        path_beat_t got;
        path_beat_t want;
        if (rst_n && out_valid && out_ready) begin
            got = {step_x, step_y, has_step, found, last};
            n_beats++;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat %0d,%0d has=%0d found=%0d last=%0d",
                       step_x, step_y, has_step, found, last));
            end else begin
                want = expected_beats.pop_front();
                if (got.step_x !== want.step_x)
                    report($sformatf("step_x %0d, want %0d", got.step_x, want.step_x));
                if (got.step_y !== want.step_y)
                    report($sformatf("step_y %0d, want %0d", got.step_y, want.step_y));
                if (got.has_step !== want.has_step)
                    report($sformatf("has_step %0d, want %0d", got.has_step, want.has_step));
                if (got.found !== want.found)
                    report($sformatf("found %0d, want %0d", got.found, want.found));
                if (got.last !== want.last)
                    report($sformatf("last %0d, want %0d", got.last, want.last));
            end
        end
    end

    task automatic push_write(input int x, input int y, input bit blk);
        grid_item_t it;
        it = '0;
        it.mode = MODE_WRITE; it.cell_x = 3'(x); it.cell_y = 3'(y); it.blocked = blk;
        it.start_x = 3'($urandom); it.start_y = 3'($urandom);
        it.goal_x  = 3'($urandom); it.goal_y  = 3'($urandom);
        pending_items = {pending_items, it};
    endtask

    task automatic push_search(input int sx, input int sy, input int gx, input int gy);
        grid_item_t it;
        it = '0;
        it.mode = MODE_SEARCH; it.start_x = 3'(sx); it.start_y = 3'(sy);
        it.goal_x = 3'(gx); it.goal_y = 3'(gy);
        it.cell_x = 3'($urandom); it.cell_y = 3'($urandom); it.blocked = 1'($urandom);
        pending_items = {pending_items, it};
    endtask

    // all items in, all beats out, then a margin for a trailing cell write
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) reg_width = val;
        else reg_height = val;
    endtask

    initial
    begin
        int roll;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 4'd0;
        hold_go = 1'b0;
        reg_width  = 4'd8;
        reg_height = 4'd8;
        foreach (walkable[i]) walkable[i] = 1;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // map sweep after reset
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        write_reg(CFG_WIDTH, 4'd8);
        write_reg(CFG_HEIGHT, 4'd8);

        // open grid corner to corner, both ways, and start on goal
        push_search(0, 0, 7, 7);
        push_search(7, 7, 0, 0);
        push_search(3, 3, 3, 3);
        // wall across row 3 with a gap at column 7
        for (int x = 0; x < 7; x++) push_write(x, 3, 1);
        push_search(0, 0, 0, 7);
        push_write(7, 3, 1);
        push_search(0, 0, 0, 7);     // sealed off
        push_search(0, 0, 0, 3);     // goal blocked
        push_search(1, 3, 0, 0);     // start blocked
        push_write(7, 3, 0);
        push_search(7, 7, 7, 0);
        wait_idle();

        // zero width counts as one, fifteen height counts as eight
        write_reg(CFG_WIDTH, 4'd0);
        write_reg(CFG_HEIGHT, 4'd15);
        push_search(0, 0, 0, 7);
        push_search(1, 0, 0, 0);     // start outside
        push_search(0, 0, 0, 8 - 1);
        push_write(2, 2, 1);         // outside, ignored
        push_search(0, 7, 0, 2);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       begin write_reg(CFG_WIDTH, 4'd8); write_reg(CFG_HEIGHT, 4'd8); end
                1:       begin write_reg(CFG_WIDTH, 4'd1); write_reg(CFG_HEIGHT, 4'd1); end
                default: begin
                    write_reg(CFG_WIDTH, 4'($urandom_range(0, 15)));
                    write_reg(CFG_HEIGHT, 4'($urandom_range(0, 15)));
                end
            endcase
            for (int k = 0; k < 24; k++) begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    push_write($urandom_range(0, 7), $urandom_range(0, 7),
                               $urandom_range(0, 2) == 0);
                else
                    push_search($urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 7));
            end
            if (ph == 0) hold_go <= 1'b1;
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (expected_beats.size() > 0)
            report($sformatf("%0d beats never arrived", expected_beats.size()));
        $display("Covered %0d searches (%0d reached the goal) and %0d cell writes, %0d beats.",
                 n_searches, n_found, n_writes, n_beats);
        $display("Grid sizes swept from 1x1 up to 8x8, incl. clamped register values.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Timeout with %0d items and %0d beats outstanding",
                 pending_items.size(), expected_beats.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gap_pkg.sv
rtl/core/gap_ram.sv
rtl/core/grid_astar_path_finder.sv
tb/sv/tb_grid_astar_path_finder.sv
